>>> sv/prt_pkg.sv
// Shared types, codes and constants for the pump run timer controller.
`default_nettype none

package prt_pkg;

    // Field widths
    localparam int DUR_W     = 7;
    localparam int SECS_W    = 13;
    localparam int STAMP_W   = 32;
    localparam int LP_W      = 16;
    localparam int STORED_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_DURATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS      = 1'd1;

    // Timing constants
    localparam logic [DUR_W-1:0]  DUR_DEFAULT  = 7'd30;
    localparam logic [DUR_W-1:0]  DUR_MAX      = 7'd100;
    localparam logic [DUR_W-1:0]  DUR_STEP     = 7'd5;
    localparam logic [SECS_W-1:0] SEC_PER_MIN  = 13'd60;
    localparam logic [LP_W-1:0]   LP_DEFAULT   = 16'd2000;

    // Divide by 60 as a multiply by ceil(2^20/60), exact for counts below 8192
    localparam int DIV_SHIFT = 20;
    localparam int PROD_W    = 28;
    localparam logic [PROD_W-1:0] RECIP_60 = 28'd17477;

    typedef enum logic [1:0] {
        START_NONE   = 2'd0,
        START_MANUAL = 2'd1,
        START_SENSOR = 2'd2
    } start_ev_t;

    typedef enum logic [1:0] {
        STOP_NONE    = 2'd0,
        STOP_MANUAL  = 2'd1,
        STOP_SENSOR  = 2'd2,
        STOP_TIMEOUT = 2'd3
    } stop_ev_t;

    // One input word as held in the input register
    typedef struct packed {
        logic               sensor_high;
        logic               button_down;
        logic [STAMP_W-1:0] now_ms;
    } in_word_t;

    // One result word as held in the result register
    typedef struct packed {
        logic             motor_on;
        logic             manual_mode;
        logic [DUR_W-1:0] display_minutes;
        logic [DUR_W-1:0] duration_minutes;
        logic             duration_saved;
        start_ev_t        start_event;
        stop_ev_t         stop_event;
    } out_word_t;

endpackage

`default_nettype wire

>>> sv/prt_if.sv
// Handshake channels for input samples and result words.
`default_nettype none

interface prt_sample_if;
    logic        valid;
    logic        ready;
    logic        sensor_high;
    logic        button_down;
    logic [31:0] now_ms;

    modport source (output valid, output sensor_high, output button_down, output now_ms,
                    input ready);
    modport sink   (input valid, input sensor_high, input button_down, input now_ms,
                    output ready);
endinterface

interface prt_result_if;
    logic       valid;
    logic       ready;
    logic       motor_on;
    logic       manual_mode;
    logic [6:0] display_minutes;
    logic [6:0] duration_minutes;
    logic       duration_saved;
    logic [1:0] start_event;
    logic [1:0] stop_event;

    modport source (output valid, output motor_on, output manual_mode,
                    output display_minutes, output duration_minutes,
                    output duration_saved, output start_event, output stop_event,
                    input ready);
    modport sink   (input valid, input motor_on, input manual_mode,
                    input display_minutes, input duration_minutes,
                    input duration_saved, input start_event, input stop_event,
                    output ready);
endinterface

`default_nettype wire

>>> sv/prt_in_stage.sv
// Input register: captures one sample word and hands it to the control core.
`default_nettype none

module prt_in_stage (
    input  wire logic        clk,
    input  wire logic        rst_n,
    prt_sample_if.sink       sample,
    output prt_pkg::in_word_t word,
    output logic             word_valid,
    input  wire logic        core_ready
);
    import prt_pkg::*;

    logic     valid_reg;
    in_word_t word_reg;

    // Free when empty or when the core drains the held word this cycle
    assign sample.ready = !valid_reg || core_ready;
    assign word         = word_reg;
    assign word_valid   = valid_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample.valid && sample.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (core_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            word_reg.sensor_high <= sample.sensor_high;
            word_reg.button_down <= sample.button_down;
            word_reg.now_ms      <= sample.now_ms;
        end
    end

endmodule

`default_nettype wire

>>> sv/prt_ctrl_core.sv
// Control core: timer state, register writes, per-word update and result register.
`default_nettype none

module prt_ctrl_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [prt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [prt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire prt_pkg::in_word_t               word,
    input  wire logic                            word_valid,
    output logic                                 core_ready,
    prt_result_if.source                         result
);
    import prt_pkg::*;

    // State
    logic               run_reg,  run_next;
    logic               man_reg,  man_next;
    logic [SECS_W-1:0]  secs_reg, secs_next;
    logic [DUR_W-1:0]   dur_reg,  dur_next;
    logic [STAMP_W-1:0] ps_reg,   ps_next;
    logic               pa_reg,   pa_next;
    logic [LP_W-1:0]    lp_reg,   lp_next;
    logic               res_valid_reg, res_valid_next;
    out_word_t          res_reg,  res_next;

    // Working values
    logic               take;
    logic [STAMP_W-1:0] elapsed;
    logic [STAMP_W-1:0] lp_wide;
    logic [DUR_W-1:0]   dur_inc;
    logic [DUR_W-1:0]   dur_load;
    logic [STORED_W-1:0] stored;
    logic [SECS_W-1:0]  cnt;
    logic [PROD_W-1:0]  prod;
    logic [DUR_W-1:0]   disp;
    logic               saved;
    start_ev_t          start_ev;
    stop_ev_t           stop_ev;

    assign core_ready = !res_valid_reg || result.ready;
    assign take       = word_valid && core_ready;
    assign lp_wide    = {{(STAMP_W-LP_W){1'b0}}, lp_reg};
    assign dur_inc    = dur_reg + DUR_STEP;
    assign stored     = cfg_wdata[STORED_W-1:0];
    assign dur_load   = (stored == '0 || stored > {1'b0, DUR_MAX}) ? DUR_DEFAULT
                                                                   : stored[DUR_W-1:0];

    // Next state for one word or one register write
    always_comb
    begin
        run_next  = run_reg;
        man_next  = man_reg;
        secs_next = secs_reg;
        dur_next  = dur_reg;
        ps_next   = ps_reg;
        pa_next   = pa_reg;
        lp_next   = lp_reg;
        elapsed   = '0;
        saved     = 1'b0;
        start_ev  = START_NONE;
        stop_ev   = STOP_NONE;
        cnt       = '0;
        prod      = '0;
        disp      = '0;

        if (take)
        begin
            // Button: long press steps duration, short release toggles manual run
            if (word.button_down)
            begin
                pa_next = 1'b1;
                if (!pa_reg)
                begin
                    ps_next = word.now_ms;
                end
                elapsed = word.now_ms - ps_next;
                if (elapsed > lp_wide)
                begin
                    dur_next = (dur_inc > DUR_MAX) ? DUR_STEP : dur_inc;
                    saved    = 1'b1;
                    ps_next  = word.now_ms;
                end
            end
            else
            begin
                elapsed = word.now_ms - ps_reg;
                if (pa_reg && elapsed < lp_wide)
                begin
                    if (!man_reg)
                    begin
                        man_next  = 1'b1;
                        run_next  = 1'b1;
                        secs_next = SECS_W'(dur_next) * SEC_PER_MIN;
                        start_ev  = START_MANUAL;
                    end
                    else
                    begin
                        man_next = 1'b0;
                        run_next = 1'b0;
                        stop_ev  = STOP_MANUAL;
                    end
                end
                pa_next = 1'b0;
                ps_next = '0;
            end

            // Sensor control outside a manual run
            if (word.sensor_high && !man_next && !run_next)
            begin
                run_next  = 1'b1;
                secs_next = SECS_W'(dur_next) * SEC_PER_MIN;
                start_ev  = START_SENSOR;
            end
            else if (!word.sensor_high && !man_next && run_next)
            begin
                run_next = 1'b0;
                stop_ev  = STOP_SENSOR;
            end

            // Countdown, minutes shown rounded up
            if (run_next)
            begin
                cnt  = (secs_next != '0) ? secs_next - 1'b1 : '0;
                prod = PROD_W'(cnt) * RECIP_60;
                disp = prod[DIV_SHIFT +: DUR_W] + 1'b1;
                if (cnt == '0)
                begin
                    run_next  = 1'b0;
                    man_next  = 1'b0;
                    secs_next = SECS_W'(dur_next) * SEC_PER_MIN;
                    stop_ev   = STOP_TIMEOUT;
                end
                else
                begin
                    secs_next = cnt;
                end
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STORED_DURATION:
                begin
                    dur_next = dur_load;
                    if (!run_reg)
                    begin
                        secs_next = SECS_W'(dur_load) * SEC_PER_MIN;
                    end
                end
                CFG_LONG_PRESS:
                begin
                    lp_next = cfg_wdata[LP_W-1:0];
                end
                default:
                begin
                    lp_next = lp_reg;
                end
            endcase
        end
    end

    // Result word
    always_comb
    begin
        res_next.motor_on         = run_next;
        res_next.manual_mode      = man_next;
        res_next.display_minutes  = disp;
        res_next.duration_minutes = dur_next;
        res_next.duration_saved   = saved;
        res_next.start_event      = start_ev;
        res_next.stop_event       = stop_ev;
        res_valid_next            = take ? 1'b1 : (result.ready ? 1'b0 : res_valid_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            man_reg       <= 1'b0;
            secs_reg      <= SECS_W'(DUR_DEFAULT) * SEC_PER_MIN;
            dur_reg       <= DUR_DEFAULT;
            ps_reg        <= '0;
            pa_reg        <= 1'b0;
            lp_reg        <= LP_DEFAULT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            man_reg       <= man_next;
            secs_reg      <= secs_next;
            dur_reg       <= dur_next;
            ps_reg        <= ps_next;
            pa_reg        <= pa_next;
            lp_reg        <= lp_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.motor_on         = res_reg.motor_on;
    assign result.manual_mode      = res_reg.manual_mode;
    assign result.display_minutes  = res_reg.display_minutes;
    assign result.duration_minutes = res_reg.duration_minutes;
    assign result.duration_saved   = res_reg.duration_saved;
    assign result.start_event      = res_reg.start_event;
    assign result.stop_event       = res_reg.stop_event;

endmodule

`default_nettype wire

>>> sv/pump_run_timer_controller.sv
// Top level of the pump run timer controller.
`default_nettype none

// Each sample word is one one-second control pass (sensor level, button level, millisecond
// stamp) and yields exactly one result word. A word can be taken every clock cycle while the
// result side does not stall. An accepted word is held in the input register while the
// control core works on it, and the state update goes straight into the result register,
// which presents the result word. A stalled result does not block an empty input register,
// so one more word can be held while it waits. Register writes (index 0 stored duration,
// index 1 long-press time) take effect at the next edge if no word is taken in that cycle,
// and are meant to be issued only while no word is in flight.
module pump_run_timer_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [prt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [prt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    prt_sample_if.sink                           sample,
    prt_result_if.source                         result
);
    import prt_pkg::*;

    in_word_t word;
    logic     word_valid;
    logic     core_ready;

    // Input register
    prt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .word       (word),
        .word_valid (word_valid),
        .core_ready (core_ready)
    );

    // Timer state and result register
    prt_ctrl_core u_ctrl_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .word       (word),
        .word_valid (word_valid),
        .core_ready (core_ready),
        .result     (result)
    );

    // A manual run always drives the motor
    a_manual_implies_motor: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.manual_mode |-> result.motor_on)
        else $error("manual mode shown with motor off");

    // End of countdown leaves the motor off and shows the last minute
    a_timeout_word: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.stop_event == STOP_TIMEOUT
        |-> !result.motor_on && result.display_minutes == 7'd1)
        else $error("timeout word inconsistent");

    // Any start leaves the motor running
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.start_event != START_NONE |-> result.motor_on)
        else $error("start event with motor off");

    // Duration and display stay in range
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.duration_minutes != 7'd0
        && result.duration_minutes <= DUR_MAX && result.display_minutes <= DUR_MAX)
        else $error("duration or display out of range");

endmodule

`default_nettype wire

>>> bench/pump_run_timer_controller_tb.sv
// Self-checking testbench for the pump run timer controller.
`default_nettype none

module pump_run_timer_controller_tb;
    import prt_pkg::*;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    // One line of the directed table
    typedef struct {
        row_kind_t             kind;
        logic                  sensor;
        logic                  button;
        logic [STAMP_W-1:0]    stamp;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        bit                    typed;
        out_word_t             want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    prt_sample_if smp ();
    prt_result_if res ();

    pump_run_timer_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (smp),
        .result    (res)
    );

    // Shadow copy of the controller state
    logic                pump_running;
    logic                manual_active;
    logic [SECS_W-1:0]   secs_left;
    logic [DUR_W-1:0]    dur_now;
    logic [STAMP_W-1:0]  press_t0;
    logic                press_held;
    logic [LP_W-1:0]     hold_ms;

    out_word_t pending_results[$];
    plan_row_t plan[$];
    int        errors;
    int        words_checked;
    bit        calm;
    int        hold_requests;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #3_000_000;
        $display("pump_run_timer_controller regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at word %0d, %s: got %0d, want %0d", words_checked, what, got, want);
        errors++;
    endtask

    // Register write seen by the shadow model
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        logic [STORED_W-1:0] stored;
        stored = data[STORED_W-1:0];
        if (idx == CFG_STORED_DURATION)
        begin
            if (stored < 1 || stored > DUR_MAX)
                dur_now = DUR_DEFAULT;
            else
                dur_now = stored[DUR_W-1:0];
            if (!pump_running)
                secs_left = dur_now * SEC_PER_MIN;
        end
        else if (idx == CFG_LONG_PRESS)
            hold_ms = data;
    endfunction

    // One control pass: button, then sensor, then countdown
    function automatic out_word_t run_pass(input logic sensor, input logic button,
                                           input logic [STAMP_W-1:0] stamp);
        out_word_t          w;
        logic [STAMP_W-1:0] held;
        logic [DUR_W-1:0]   disp;
        logic               saved;
        start_ev_t          st;
        stop_ev_t           sp;
        disp  = '0;
        saved = 1'b0;
        st    = START_NONE;
        sp    = STOP_NONE;

        if (button)
        begin
            if (!press_held)
            begin
                press_held = 1'b1;
                press_t0   = stamp;
            end
            held = stamp - press_t0;
            if (held > {16'd0, hold_ms})
            begin
                dur_now = dur_now + DUR_STEP;
                if (dur_now > DUR_MAX)
                    dur_now = DUR_STEP;
                saved    = 1'b1;
                press_t0 = stamp;
            end
        end
        else
        begin
            held = stamp - press_t0;
            if (press_held && held < {16'd0, hold_ms})
            begin
                if (!manual_active)
                begin
                    manual_active = 1'b1;
                    pump_running  = 1'b1;
                    secs_left     = dur_now * SEC_PER_MIN;
                    st            = START_MANUAL;
                end
                else
                begin
                    manual_active = 1'b0;
                    pump_running  = 1'b0;
                    sp            = STOP_MANUAL;
                end
            end
            press_held = 1'b0;
            press_t0   = '0;
        end

        // Sensor only matters outside a manual run
        if (sensor && !manual_active && !pump_running)
        begin
            pump_running = 1'b1;
            secs_left    = dur_now * SEC_PER_MIN;
            st           = START_SENSOR;
        end
        else if (!sensor && !manual_active && pump_running)
        begin
            pump_running = 1'b0;
            sp           = STOP_SENSOR;
        end

        // Countdown, ends the run at zero
        if (pump_running)
        begin
            if (secs_left != 0)
                secs_left = secs_left - 1'b1;
            disp = DUR_W'(secs_left / SEC_PER_MIN + 1);
            if (secs_left == 0)
            begin
                pump_running  = 1'b0;
                manual_active = 1'b0;
                secs_left     = dur_now * SEC_PER_MIN;
                sp            = STOP_TIMEOUT;
            end
        end

        w.motor_on         = pump_running;
        w.manual_mode      = manual_active;
        w.display_minutes  = disp;
        w.duration_minutes = dur_now;
        w.duration_saved   = saved;
        w.start_event      = st;
        w.stop_event       = sp;
        return w;
    endfunction

    // Table builders
    function automatic void add_word(input logic s, input logic b, input logic [31:0] t);
        plan_row_t r;
        r          = '{kind: ROW_WORD, default: '0};
        r.sensor   = s;
        r.button   = b;
        r.stamp    = t;
        plan.push_back(r);
    endfunction

    function automatic void add_word_exp(input logic s, input logic b, input logic [31:0] t,
                                         input logic motor, input logic manual,
                                         input logic [6:0] disp, input logic [6:0] dur,
                                         input logic saved, input start_ev_t st,
                                         input stop_ev_t sp);
        plan_row_t r;
        r       = '{kind: ROW_WORD, default: '0};
        r.sensor = s;
        r.button = b;
        r.stamp  = t;
        r.typed  = 1'b1;
        r.want.motor_on         = motor;
        r.want.manual_mode      = manual;
        r.want.display_minutes  = disp;
        r.want.duration_minutes = dur;
        r.want.duration_saved   = saved;
        r.want.start_event      = st;
        r.want.stop_event       = sp;
        plan.push_back(r);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r          = '{kind: ROW_REG, default: '0};
        r.reg_idx  = idx;
        r.reg_data = data;
        plan.push_back(r);
    endfunction

    // Offer one word until taken; call and return at a falling edge
    task automatic send_word(input logic s, input logic b, input logic [31:0] t,
                             input bit typed, input out_word_t want);
        out_word_t guess;
        while (!calm && $urandom_range(99) < 33)
        begin
            smp.valid <= 1'b0;
            @(negedge clk);
        end
        smp.valid       <= 1'b1;
        smp.sensor_high <= s;
        smp.button_down <= b;
        smp.now_ms      <= t;
        do
            @(posedge clk);
        while (!(smp.valid && smp.ready));
        guess = run_pass(s, b, t);
        pending_results.push_back(typed ? want : guess);
        @(negedge clk);
    endtask

    // Register write once nothing is in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        smp.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        apply_reg(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random words; time steps are spread around the long-press threshold
    task automatic run_phase(input int n_words, input int sensor_flip, input int button_flip);
        logic        s_lvl;
        logic        b_lvl;
        logic [31:0] t;
        int unsigned span;
        int unsigned pick;
        s_lvl = 1'($urandom_range(1));
        b_lvl = 1'b0;
        t     = $urandom;
        for (int i = 0; i < n_words; i++)
        begin
            span = hold_ms;
            if ($urandom_range(999) < sensor_flip)
                s_lvl = !s_lvl;
            if ($urandom_range(99) < button_flip)
                b_lvl = !b_lvl;
            pick = $urandom_range(99);
            if (pick < 40)
                t = t + $urandom_range(span / 2, 0);
            else if (pick < 55)
                t = t + span - 1 + $urandom_range(2, 0);
            else if (pick < 92)
                t = t + $urandom_range(span * 2, span / 2);
            else
                t = $urandom;
            send_word(s_lvl, b_lvl, t, 1'b0, '0);
        end
    endtask

    // Result side: random stalls plus a requested long hold
    initial
    begin : sink_drive
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= calm || ($urandom_range(99) >= 33);
        end
    end

    // Compare each taken result word with the oldest prediction
    always @(posedge clk)
    begin : check_words
        out_word_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("word with none expected", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (res.motor_on !== want.motor_on)
                    report_mismatch("motor_on", res.motor_on, want.motor_on);
                if (res.manual_mode !== want.manual_mode)
                    report_mismatch("manual_mode", res.manual_mode, want.manual_mode);
                if (res.display_minutes !== want.display_minutes)
                    report_mismatch("display_minutes", res.display_minutes,
                                    want.display_minutes);
                if (res.duration_minutes !== want.duration_minutes)
                    report_mismatch("duration_minutes", res.duration_minutes,
                                    want.duration_minutes);
                if (res.duration_saved !== want.duration_saved)
                    report_mismatch("duration_saved", res.duration_saved,
                                    want.duration_saved);
                if (res.start_event !== 2'(want.start_event))
                    report_mismatch("start_event", res.start_event, want.start_event);
                if (res.stop_event !== 2'(want.stop_event))
                    report_mismatch("stop_event", res.stop_event, want.stop_event);
            end
            words_checked++;
        end
    end

    // Main sequence
    initial
    begin
        logic [STORED_W-1:0] dur_cfg;
        logic [LP_W-1:0]     lp_cfg;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        smp.valid       = 1'b0;
        smp.sensor_high = 1'b0;
        smp.button_down = 1'b0;
        smp.now_ms      = '0;
        errors          = 0;
        words_checked   = 0;
        calm            = 1'b0;
        hold_requests   = 0;

        pump_running  = 1'b0;
        manual_active = 1'b0;
        dur_now       = DUR_DEFAULT;
        secs_left     = DUR_DEFAULT * SEC_PER_MIN;
        press_t0      = '0;
        press_held    = 1'b0;
        hold_ms       = LP_DEFAULT;

        // Directed table
        add_word_exp(0, 0, 32'd0,    0, 0, 0,   30,  0, START_NONE,   STOP_NONE);
        add_word_exp(1, 0, 32'd1000, 1, 0, 30,  30,  0, START_SENSOR, STOP_NONE);
        add_word_exp(0, 0, 32'd2000, 0, 0, 0,   30,  0, START_NONE,   STOP_SENSOR);
        add_reg(CFG_STORED_DURATION, 16'd100);
        add_word_exp(1, 0, 32'd3000, 1, 0, 100, 100, 0, START_SENSOR, STOP_NONE);
        add_word_exp(0, 0, 32'd4000, 0, 0, 0,   100, 0, START_NONE,   STOP_SENSOR);
        add_reg(CFG_STORED_DURATION, 16'd1);
        // short press toggles a manual run on
        add_word_exp(0, 1, 32'd10000, 0, 0, 0, 1, 0, START_NONE,   STOP_NONE);
        add_word_exp(0, 0, 32'd10500, 1, 1, 1, 1, 0, START_MANUAL, STOP_NONE);
        // manual stop and sensor start in the same pass
        add_word(1, 1, 32'd20000);
        add_word_exp(1, 0, 32'd21999, 1, 0, 1, 1, 0, START_SENSOR, STOP_MANUAL);
        // release at exactly the threshold does nothing
        add_word(0, 1, 32'd30000);
        add_word_exp(0, 0, 32'd32000, 0, 0, 0, 1, 0, START_NONE, STOP_NONE);
        // long press steps the duration, quick release after it toggles
        add_word(0, 1, 32'd40000);
        add_word_exp(0, 1, 32'd42001, 0, 0, 0, 6, 1, START_NONE, STOP_NONE);
        add_word(0, 0, 32'd42500);
        add_word(0, 0, 32'd43000);
        // invalid stored values load the default; no reload while running
        add_reg(CFG_STORED_DURATION, 16'd0);
        add_word(0, 0, 32'd44000);
        add_reg(CFG_STORED_DURATION, 16'hFFFF);
        add_reg(CFG_STORED_DURATION, 16'd98);
        // time stamp wrap and duration wrap past the maximum
        add_word(0, 1, 32'hFFFF_FFFF);
        add_word(0, 1, 32'h0000_0800);
        add_word_exp(0, 0, 32'h0000_0900, 0, 0, 0, 5, 0, START_NONE, STOP_MANUAL);
        // largest threshold
        add_reg(CFG_LONG_PRESS, 16'hFFFF);
        add_word(0, 1, 32'h0000_1000);
        add_word_exp(0, 1, 32'h0001_0FFF, 0, 0, 0, 5,  0, START_NONE, STOP_NONE);
        add_word_exp(0, 1, 32'h0001_1000, 0, 0, 0, 10, 1, START_NONE, STOP_NONE);
        // zero threshold: every hold is long, no release toggles
        add_reg(CFG_LONG_PRESS, 16'd0);
        add_word(0, 1, 32'd5);
        add_word(0, 1, 32'd6);
        add_word_exp(0, 0, 32'd6, 0, 0, 0, 20, 0, START_NONE, STOP_NONE);
        add_reg(CFG_LONG_PRESS, 16'd1);

        // Reset
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            else
                send_word(plan[i].sensor, plan[i].button, plan[i].stamp,
                          plan[i].typed, plan[i].want);
        end

        // Random phases, each under its own register settings
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0:
                begin
                    dur_cfg = 8'd1;
                    lp_cfg  = LP_DEFAULT;
                end
                1:
                begin
                    dur_cfg = 8'd100;
                    lp_cfg  = 16'hFFFF;
                end
                2:
                begin
                    dur_cfg = 8'd0;
                    lp_cfg  = 16'd1;
                end
                3, 6, 9:
                begin
                    dur_cfg = 8'($urandom_range(2, 1));
                    lp_cfg  = LP_DEFAULT;
                end
                4:
                begin
                    dur_cfg = 8'd255;
                    lp_cfg  = 16'h8000;
                end
                5:
                begin
                    dur_cfg = 8'd101;
                    lp_cfg  = 16'($urandom_range(300, 1));
                end
                default:
                begin
                    dur_cfg = 8'($urandom_range(255));
                    lp_cfg  = 16'($urandom_range(65535, 1));
                end
            endcase
            write_reg(CFG_STORED_DURATION, {8'($urandom), dur_cfg});
            write_reg(CFG_LONG_PRESS, lp_cfg);
            calm = (p == 0);
            if (p == 4)
                hold_requests++;
            // long sensor runs let short durations count down to the end
            if (p % 3 == 0)
                run_phase(200, 4, 3);
            else
                run_phase(130, 150, 35);
        end
        calm = 1'b0;
        smp.valid <= 1'b0;

        // Drain
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("pump_run_timer_controller regression: pass");
        else
            $display("pump_run_timer_controller regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
